// File: design/decorated_path_crc32_hasher_top_defines.svh
// assertion macros for the decorated path hasher
`ifndef DECORATED_PATH_CRC32_HASHER_TOP_DEFINES_SVH
`define DECORATED_PATH_CRC32_HASHER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dph_pkg.sv
`default_nettype none

package dph_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;
    localparam logic [7:0]  CH_MARK   = 8'h23;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_ESCAPE = 8'h5C;
    localparam logic [1:0]  RUN_MAX   = 2'd3;

    typedef logic [31:0] crc_table_t [256];

    // one table entry, bitwise form, elaboration only
    function automatic logic [31:0] table_entry(input logic [7:0] idx);
        logic [31:0] x;
        x = {24'd0, idx};
        for (int k = 0; k < 8; k++)
        begin
            x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
        end
        return x;
    endfunction

    function automatic crc_table_t build_table();
        crc_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = table_entry(8'(i));
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = build_table();

    // constant form of one byte step, for reset values
    function automatic logic [31:0] crc_add_const(input logic [31:0] crc,
                                                  input logic [7:0] data);
        return (crc >> 8) ^ table_entry(crc[7:0] ^ data);
    endfunction

    // mark chain from a zero seed hold
    localparam logic [31:0] MARK1_RESET = crc_add_const(32'd0, CH_MARK);
    localparam logic [31:0] MARK2_RESET = crc_add_const(MARK1_RESET, CH_MARK);

endpackage

`default_nettype wire

// File: design/decorated_path_crc32_hasher_top.sv
`default_nettype none

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+----------------------------------------
// char     | in        | char_valid / char_stall | char_byte, is_first, is_last, start_seed
// hash     | out       | hash_valid / hash_stall | path_hash
//
// one word per cycle while char_stall is low; a word waits in the input register,
// is hashed by a single rom lookup on the running crc, and a last word's hash
// then lands in the output register once that register is free.
// reset clears the running crc, seed hold, escape flag, run count and valids.
// char_stall rises only when a last word waits in the input register while the
// output register still holds a hash that hash_stall keeps there.

`include "decorated_path_crc32_hasher_top_defines.svh"

module decorated_path_crc32_hasher_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_byte,
    input  wire logic        is_first,
    input  wire logic        is_last,
    input  wire logic [31:0] start_seed,
    output logic             hash_valid,
    input  wire logic        hash_stall,
    output logic      [31:0] path_hash
);

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic [31:0] s1_seed_reg;

    // hashing state
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] hold_reg;
    logic [31:0] hold_next;
    logic        esc_reg;
    logic        esc_next;
    logic [1:0]  run_reg;
    logic [1:0]  run_next;

    // "###" chain off the seed hold: mark1 = hold+'#', mark2 = hold+'##'
    logic [31:0] mark1_reg;
    logic [31:0] mark1_next;
    logic [31:0] mark2_reg;
    logic [31:0] mark2_next;
    logic [31:0] mark3;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_hash_reg;

    logic        accept;
    logic        fire;
    logic [31:0] seed_inv;
    logic [31:0] crc_base;
    logic        esc_base;
    logic [1:0]  run_base;
    logic        is_mark;
    logic        arm;
    logic        skip;
    logic [31:0] crc_plain;

    assign accept = char_valid && !char_stall;

    // a last word may only move on once the output register is free
    assign fire       = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !hash_stall);
    assign char_stall = s1_valid_reg && !fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // a leading slash forces the seed to zero before it is inverted
    assign seed_inv = (s1_char_reg == dph_pkg::CH_SLASH) ? 32'hFFFFFFFF : ~s1_seed_reg;

    // a first word restarts from the fresh seed, clear escape and run
    assign crc_base = s1_first_reg ? seed_inv : crc_reg;
    assign esc_base = s1_first_reg ? 1'b0 : esc_reg;
    assign run_base = s1_first_reg ? 2'd0 : run_reg;

    assign is_mark = (s1_char_reg == dph_pkg::CH_MARK);

    always_comb
    begin
        if (!is_mark)
        begin
            run_next = 2'd0;
        end
        else if (run_base == dph_pkg::RUN_MAX)
        begin
            run_next = dph_pkg::RUN_MAX;
        end
        else
        begin
            run_next = 2'(run_base + 2'd1);
        end
    end

    // unescaped backslash arms the escape, unescaped slash is dropped
    assign arm  = (s1_char_reg == dph_pkg::CH_ESCAPE) && !esc_base;
    assign skip = (s1_char_reg == dph_pkg::CH_SLASH) && !esc_base;

    dph_crc_byte u_crc_plain
    (
        .crc_in  (crc_base),
        .data    (s1_char_reg),
        .crc_out (crc_plain)
    );

    dph_crc_byte u_crc_mark3
    (
        .crc_in  (mark2_reg),
        .data    (dph_pkg::CH_MARK),
        .crc_out (mark3)
    );

    always_comb
    begin
        crc_next = crc_base;
        esc_next = esc_base;
        if (arm)
        begin
            esc_next = 1'b1;
        end
        else if (!skip)
        begin
            // third or later raw mark restarts at seed hashed over "###"
            crc_next = (run_next == dph_pkg::RUN_MAX) ? mark3 : crc_plain;
            esc_next = 1'b0;
        end
    end

    assign hold_next = (fire && s1_first_reg) ? seed_inv : hold_reg;

    // the chain runs every cycle; a third mark is at least two words behind
    // the first, by when mark2 has caught up with a new hold
    dph_crc_byte u_crc_mark1
    (
        .crc_in  (hold_next),
        .data    (dph_pkg::CH_MARK),
        .crc_out (mark1_next)
    );

    dph_crc_byte u_crc_mark2
    (
        .crc_in  (mark1_reg),
        .data    (dph_pkg::CH_MARK),
        .crc_out (mark2_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!hash_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            crc_reg       <= 32'd0;
            hold_reg      <= 32'd0;
            esc_reg       <= 1'b0;
            run_reg       <= 2'd0;
            mark1_reg     <= dph_pkg::MARK1_RESET;
            mark2_reg     <= dph_pkg::MARK2_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            hold_reg      <= hold_next;
            mark1_reg     <= mark1_next;
            mark2_reg     <= mark2_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                crc_reg <= crc_next;
                esc_reg <= esc_next;
                run_reg <= run_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg  <= char_byte;
            s1_first_reg <= is_first;
            s1_last_reg  <= is_last;
            s1_seed_reg  <= start_seed;
        end
        if (fire && s1_last_reg)
        begin
            out_hash_reg <= ~crc_next;
        end
    end

    assign hash_valid = out_valid_reg;
    assign path_hash  = out_hash_reg;

    // checks
    `DPH_ASSERT_NEXT(a_last_gives_hash, fire && s1_last_reg, hash_valid,
        "last word did not produce a hash")
    `DPH_ASSERT_NOW(a_stall_needs_word, char_stall, s1_valid_reg && s1_last_reg && hash_valid,
        "input stalled without a waiting last word")
    `DPH_ASSERT_NEXT(a_slash_seed_zero,
        fire && s1_first_reg && (s1_char_reg == dph_pkg::CH_SLASH),
        hold_reg == 32'hFFFFFFFF,
        "leading slash did not zero the seed")

endmodule

`default_nettype wire

// File: design/dph_crc_byte.sv
`default_nettype none

// one reflected crc-32 byte step through the rom
module dph_crc_byte
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [31:0] crc_out
);

    logic [7:0] idx;

    assign idx     = crc_in[7:0] ^ data;
    assign crc_out = (crc_in >> 8) ^ dph_pkg::CRC_TABLE[idx];

endmodule

`default_nettype wire
